### hdl/assert_macros.svh
// Assertion helpers for the file that checks this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication does not hold");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication does not hold");

`endif

### hdl/rsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_pkg
// Types and constants of the stereo linear resampler.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_BITS      = PHASE_FRAC_BITS + 2;
  localparam int STEP_BITS       = 18;
  localparam int DIFF_BITS       = SAMPLE_BITS + 1;
  localparam int FRAC_BITS       = PHASE_FRAC_BITS + 1;
  localparam int PROD_BITS       = DIFF_BITS + FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [STEP_BITS-1:0]          step_t;

  localparam phase_t PHASE_ONE  = phase_t'(1) << PHASE_FRAC_BITS;
  localparam phase_t STEP_MIN   = phase_t'((2 ** PHASE_FRAC_BITS + 9) / 10);
  localparam phase_t STEP_MAX   = phase_t'(3 * (2 ** PHASE_FRAC_BITS));
  localparam phase_t STEP_RESET = PHASE_ONE;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_wr;
    logic accept;
    logic mul;
    logic emit;
  } rsl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run;
    logic last;
  } rsl_sts_t;

endpackage
`default_nettype wire

### hdl/rsl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_if
// Valid/ready channels of the stereo linear resampler.
// ----------------------------------------------------------------------------
interface rsl_frame_if;
  import rsl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t in_left;
  sample_t in_right;
  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface rsl_result_if;
  import rsl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;
  logic    last_of_run;
  modport source (output valid, output out_left, output out_right,
                  output last_of_run, input ready);
  modport sink (input valid, input out_left, input out_right,
                input last_of_run, output ready);
endinterface

interface rsl_cfg_if;
  import rsl_pkg::*;
  logic  valid;
  logic  ready;
  step_t speed_step;
  modport source (output valid, output speed_step, input ready);
  modport sink (input valid, input speed_step, output ready);
endinterface
`default_nettype wire

### hdl/rsl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_ctrl
// Sequencer of the resampler: takes frames, steps the interpolation and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module rsl_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  output rsl_pkg::rsl_cmd_t cmd,
  input  rsl_pkg::rsl_sts_t sts
);
  import rsl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready  = (state == S_IDLE);
  // A pending frame request wins, so a frame is never taken and then dropped.
  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    cmd.accept = in_valid && in_ready && !cmd.cfg_wr;
    case (state)
      S_IDLE:  cmd.mul  = 1'b0;
      S_MUL:   cmd.mul  = 1'b1;
      S_EMIT:  cmd.emit = out_free;
      default: cmd      = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.accept && sts.run) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.emit) begin
            state <= sts.last ? S_IDLE : S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/rsl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_dp
// Datapath of the resampler: speed register, read phase, frame history,
// one registered multiply per channel and the result registers.
// ----------------------------------------------------------------------------
module rsl_dp (
  input  wire               clk,
  input  wire               rst,
  input  rsl_pkg::rsl_cmd_t cmd,
  output rsl_pkg::rsl_sts_t sts,
  input  rsl_pkg::step_t    cfg_step,
  input  rsl_pkg::sample_t  in_left,
  input  rsl_pkg::sample_t  in_right,
  output rsl_pkg::sample_t  out_left,
  output rsl_pkg::sample_t  out_right,
  output logic              last_of_run
);
  import rsl_pkg::*;

  phase_t  step;
  phase_t  phase;
  logic    have_prev;
  sample_t prev_left;
  sample_t prev_right;
  sample_t cur_left;
  sample_t cur_right;
  logic signed [PROD_BITS-1:0] prod_left;
  logic signed [PROD_BITS-1:0] prod_right;

  phase_t  step_sat;
  logic [PHASE_BITS:0] phase_adv;
  logic signed [DIFF_BITS-1:0] diff_left;
  logic signed [DIFF_BITS-1:0] diff_right;
  logic signed [FRAC_BITS-1:0] frac;
  logic signed [DIFF_BITS-1:0] q_left;
  logic signed [DIFF_BITS-1:0] q_right;
  logic signed [DIFF_BITS-1:0] sum_left;
  logic signed [DIFF_BITS-1:0] sum_right;

  always_comb begin
    if (phase_t'(cfg_step) < STEP_MIN) begin
      step_sat = STEP_MIN;
    end else if (phase_t'(cfg_step) > STEP_MAX) begin
      step_sat = STEP_MAX;
    end else begin
      step_sat = phase_t'(cfg_step);
    end
  end

  assign phase_adv = {1'b0, phase} + {1'b0, step};
  assign sts.run   = have_prev && (phase < PHASE_ONE);
  assign sts.last  = phase_adv >= {1'b0, PHASE_ONE};

  assign diff_left  = DIFF_BITS'(cur_left) - DIFF_BITS'(prev_left);
  assign diff_right = DIFF_BITS'(cur_right) - DIFF_BITS'(prev_right);
  assign frac       = $signed({1'b0, phase[PHASE_FRAC_BITS-1:0]});

  // The arithmetic shift gives the floor of the scaled difference.
  assign q_left    = DIFF_BITS'(prod_left >>> PHASE_FRAC_BITS);
  assign q_right   = DIFF_BITS'(prod_right >>> PHASE_FRAC_BITS);
  assign sum_left  = DIFF_BITS'(prev_left) + q_left;
  assign sum_right = DIFF_BITS'(prev_right) + q_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_RESET;
      phase     <= '0;
      have_prev <= 1'b0;
    end else if (cmd.cfg_wr) begin
      step      <= step_sat;
      phase     <= '0;
      have_prev <= 1'b0;
    end else if (cmd.accept) begin
      if (!have_prev) begin
        have_prev <= 1'b1;
      end else if (phase >= PHASE_ONE) begin
        phase <= phase - PHASE_ONE;
      end
    end else if (cmd.emit) begin
      if (sts.last) begin
        phase <= PHASE_BITS'(phase_adv - {1'b0, PHASE_ONE});
      end else begin
        phase <= PHASE_BITS'(phase_adv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_left  <= in_left;
      cur_right <= in_right;
      // A frame that starts no interpolation run goes straight to history.
      if (!sts.run) begin
        prev_left  <= in_left;
        prev_right <= in_right;
      end
    end else if (cmd.emit && sts.last) begin
      prev_left  <= cur_left;
      prev_right <= cur_right;
    end
    if (cmd.mul) begin
      prod_left  <= diff_left * frac;
      prod_right <= diff_right * frac;
    end
    if (cmd.emit) begin
      out_left    <= sum_left[SAMPLE_BITS-1:0];
      out_right   <= sum_right[SAMPLE_BITS-1:0];
      last_of_run <= sts.last;
    end
  end

endmodule
`default_nettype wire

### hdl/stereo_linear_resampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top
// Stereo playback-speed changer by linear interpolation between frames.
// ----------------------------------------------------------------------------
// Each request on frame carries one stereo frame; each request on result
// carries one interpolated frame, with last_of_run marking the final one a
// frame causes. A frame that yields nothing (the first after reset or a
// speed write, or one skipped at speeds above 1.0) leaves the block idle. A
// frame that yields results runs each one through S_MUL, where the
// per-channel multiplier is registered, and then S_EMIT, where the add loads
// the result register once it is free.
// The next frame is taken while the last result still waits in its register.
// A write on cfg saturates speed_step to 0.1..3.0 in Q.16 and clears the
// phase and frame history; write it only while the block is idle.
module stereo_linear_resampler_top (
  input wire          clk,
  input wire          rst,
  rsl_frame_if.sink   frame,
  rsl_result_if.source result,
  rsl_cfg_if.sink     cfg
);
  import rsl_pkg::*;

  rsl_cmd_t cmd;
  rsl_sts_t sts;

  rsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rsl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_step    (cfg.speed_step),
    .in_left     (frame.in_left),
    .in_right    (frame.in_right),
    .out_left    (result.out_left),
    .out_right   (result.out_right),
    .last_of_run (result.last_of_run)
  );

  // A result is loaded only when the result register is free or being drained.
  `ASSERT_IMP(a_emit_into_free, clk, rst, cmd.emit, !result.valid || result.ready)
  // No new frame is taken while a run is being computed.
  `ASSERT_IMP(a_no_take_in_run, clk, rst, frame.valid && frame.ready, !cmd.mul && !cmd.emit)
  // The final result of a run hands control back to frame intake.
  `ASSERT_NXT(a_last_to_idle, clk, rst, cmd.emit && sts.last, frame.ready)
  // A speed write drops the history, so the next frame cannot start a run.
  `ASSERT_NXT(a_cfg_clears, clk, rst, cfg.valid && cfg.ready, !sts.run)

endmodule
`default_nettype wire
